// ----- hw/rtl/srmu_pkg.sv -----
// Shared types and constants for the special register move unit.
// No dependencies; used by srmu_exec and special_register_move_unit_core.
package srmu_pkg;

  typedef enum logic [2:0] {
    CMD_MFSPR = 3'd0,
    CMD_MTSPR = 3'd1,
    CMD_MTFSF = 3'd2,
    CMD_MCRXR = 3'd3,
    CMD_MCRFS = 3'd4,
    CMD_MFFS  = 3'd5
  } cmd_e;

  localparam logic [9:0]  SPR_XER    = 10'd1;
  localparam logic [9:0]  SPR_LR     = 10'd8;
  localparam logic [9:0]  SPR_CTR    = 10'd9;
  localparam logic [9:0]  SPR_TBL    = 10'd268;
  localparam logic [9:0]  SPR_TBU    = 10'd269;
  localparam logic [9:0]  SPR_QR_BASE = 10'd912;
  localparam logic [9:0]  SPR_HID2   = 10'd920;

  localparam logic [31:0] MFFS_HIGH  = 32'hFFF8_0000;
  localparam logic [31:0] XER_KEEP   = 32'h0FFF_FFFF;

  typedef struct packed {
    cmd_e        command;
    logic [9:0]  spr_number;
    logic [31:0] data_value;
    logic [7:0]  field_mask;
    logic [2:0]  dest_field;
    logic [2:0]  source_field;
    logic [63:0] time_base;
  } item_t;

endpackage

// ----- hw/rtl/special_register_move_unit_core.sv -----
// Special register move unit: input register, execute stage, result register.
// Depends on srmu_pkg and srmu_exec.
//
// Takes one move instruction per cycle while not stalled and returns exactly
// one 64-bit result per instruction, in order. The instruction is captured in
// an input register, then the execute stage reads and updates the register
// set (quantization registers, HID2, LR, CTR, XER, CR, FPSCR) and loads the
// result register. Throughput is one instruction per cycle while the output
// is not stalled, set by that single read-modify-write of the register set;
// back-to-back instructions see each other's updates.
// The output register stalls the pipe only while a result is held by a stall.
module special_register_move_unit_core #(
  parameter int NUM_QUANT_REGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [9:0]  spr_number_i,
  input  logic [31:0] data_value_i,
  input  logic [7:0]  field_mask_i,
  input  logic [2:0]  dest_field_i,
  input  logic [2:0]  source_field_i,
  input  logic [63:0] time_base_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_value_o
);

  srmu_pkg::item_t item_q;
  logic            s1_valid_q, s1_valid_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     result_q;
  logic [63:0]     exec_result;
  logic            exec_fire;
  logic            in_xfer;

  assign exec_fire  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !exec_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_xfer ? 1'b1 : (exec_fire ? 1'b0 : s1_valid_q);
    out_valid_d = exec_fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.command      <= srmu_pkg::cmd_e'(command_i);
      item_q.spr_number   <= spr_number_i;
      item_q.data_value   <= data_value_i;
      item_q.field_mask   <= field_mask_i;
      item_q.dest_field   <= dest_field_i;
      item_q.source_field <= source_field_i;
      item_q.time_base    <= time_base_i;
    end
    if (exec_fire) begin
      result_q <= exec_result;
    end
  end

  srmu_exec #(
    .NUM_QUANT_REGS(NUM_QUANT_REGS)
  ) u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (exec_fire),
    .item_i   (item_q),
    .result_o (exec_result)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_o)
    else $error("executed transfer produced no result");

  a_write_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && (item_q.command == srmu_pkg::CMD_MTSPR ||
                  item_q.command == srmu_pkg::CMD_MTFSF)
    |=> result_value_o == 64'd0)
    else $error("write command returned nonzero result");

  a_mffs_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && item_q.command == srmu_pkg::CMD_MFFS
    |=> result_value_o[63:32] == srmu_pkg::MFFS_HIGH)
    else $error("mffs upper word wrong");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipe");

endmodule

// ----- hw/rtl/srmu_exec.sv -----
// Execute stage: architectural register set and the single-pass move logic.
// Depends on srmu_pkg.
module srmu_exec #(
  parameter int NUM_QUANT_REGS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  srmu_pkg::item_t item_i,
  output logic [63:0]    result_o
);

  localparam int QW = (NUM_QUANT_REGS > 1) ? $clog2(NUM_QUANT_REGS) : 1;

  logic [31:0] quant_q [NUM_QUANT_REGS];
  logic [31:0] hid2_q, hid2_d;
  logic [31:0] lr_q, lr_d;
  logic [31:0] ctr_q, ctr_d;
  logic [31:0] xer_q, xer_d;
  logic [31:0] cr_q, cr_d;
  logic [31:0] fpscr_q, fpscr_d;

  logic [9:0]    qoff;
  logic          q_hit;
  logic [QW-1:0] q_idx;
  logic          q_we;
  logic [31:0]   spr_rd;
  logic [31:0]   fs_mask;
  logic [3:0]    cr_nib;
  logic [31:0]   cr_new;
  logic [2:0]    cr_pos;

  always_comb begin
    qoff  = item_i.spr_number - srmu_pkg::SPR_QR_BASE;
    q_hit = (item_i.spr_number >= srmu_pkg::SPR_QR_BASE) &&
            (qoff < 10'(NUM_QUANT_REGS));
    q_idx = qoff[QW-1:0];

    if (q_hit) begin
      spr_rd = quant_q[q_idx];
    end else begin
      unique case (item_i.spr_number)
        srmu_pkg::SPR_HID2: spr_rd = hid2_q;
        srmu_pkg::SPR_LR:   spr_rd = lr_q;
        srmu_pkg::SPR_CTR:  spr_rd = ctr_q;
        srmu_pkg::SPR_XER:  spr_rd = xer_q;
        srmu_pkg::SPR_TBL:  spr_rd = item_i.time_base[31:0];
        srmu_pkg::SPR_TBU:  spr_rd = item_i.time_base[63:32];
        default:            spr_rd = '0;
      endcase
    end

    // mask bit j selects the nibble j places up from the bottom
    for (int j = 0; j < 8; j++) begin
      fs_mask[4*j +: 4] = {4{item_i.field_mask[j]}};
    end

    if (item_i.command == srmu_pkg::CMD_MCRXR) begin
      cr_nib = xer_q[31:28];
    end else begin
      cr_nib = fpscr_q[{~item_i.source_field, 2'b00} +: 4];
    end
    cr_pos = ~item_i.dest_field;
    cr_new = cr_q;
    cr_new[{cr_pos, 2'b00} +: 4] = cr_nib;
  end

  always_comb begin
    hid2_d   = hid2_q;
    lr_d     = lr_q;
    ctr_d    = ctr_q;
    xer_d    = xer_q;
    cr_d     = cr_q;
    fpscr_d  = fpscr_q;
    q_we     = 1'b0;
    result_o = '0;
    unique case (item_i.command)
      srmu_pkg::CMD_MFSPR: begin
        result_o = {32'd0, spr_rd};
      end
      srmu_pkg::CMD_MTSPR: begin
        if (q_hit) begin
          q_we = 1'b1;
        end else begin
          unique case (item_i.spr_number)
            srmu_pkg::SPR_HID2: hid2_d = item_i.data_value;
            srmu_pkg::SPR_LR:   lr_d   = item_i.data_value;
            srmu_pkg::SPR_CTR:  ctr_d  = item_i.data_value;
            srmu_pkg::SPR_XER:  xer_d  = item_i.data_value;
            default: ;
          endcase
        end
      end
      srmu_pkg::CMD_MTFSF: begin
        fpscr_d = (fpscr_q & ~fs_mask) | (item_i.data_value & fs_mask);
      end
      srmu_pkg::CMD_MCRXR: begin
        cr_d     = cr_new;
        xer_d    = xer_q & srmu_pkg::XER_KEEP;
        result_o = {32'd0, cr_new};
      end
      srmu_pkg::CMD_MCRFS: begin
        cr_d     = cr_new;
        result_o = {32'd0, cr_new};
      end
      srmu_pkg::CMD_MFFS: begin
        result_o = {srmu_pkg::MFFS_HIGH, fpscr_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUANT_REGS; i++) begin
        quant_q[i] <= '0;
      end
      hid2_q  <= '0;
      lr_q    <= '0;
      ctr_q   <= '0;
      xer_q   <= '0;
      cr_q    <= '0;
      fpscr_q <= '0;
    end else if (fire_i) begin
      if (q_we) begin
        quant_q[q_idx] <= item_i.data_value;
      end
      hid2_q  <= hid2_d;
      lr_q    <= lr_d;
      ctr_q   <= ctr_d;
      xer_q   <= xer_d;
      cr_q    <= cr_d;
      fpscr_q <= fpscr_d;
    end
  end

endmodule
